### rtl/core/adc_pkg.sv
// shared types, constants and fixed-point helpers for the airship compensation block
// no dependencies; used by every module in rtl/core except adc_delay
package adc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUAT_BITS     = 30;
    localparam int CFG_IDX_W     = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASS_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ECC_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ECC_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ECC_Z  = 3'd6;

    // pipeline timing
    localparam int SQRT_STEPS = 32;
    localparam int NORM_STAGE = 2 + SQRT_STEPS;
    localparam int GRAV_STAGE = 7;
    localparam int PIPE_LAT   = NORM_STAGE + 5;

    typedef logic signed [31:0] fx_t;
    typedef logic signed [33:0] qp_t;
    typedef logic [2:0][31:0] vec3_t;
    typedef logic [2:0][2:0][31:0] mat3_t;

    function automatic fx_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // product floored by sh bits, saturated
    function automatic fx_t fmul(input fx_t a, input fx_t b, input int sh);
        logic signed [63:0] p;
        p = a * b;
        return sat32(p >>> sh);
    endfunction

    // quaternion-scale product floored by 30 bits
    function automatic qp_t qmul(input fx_t a, input fx_t b);
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = a * b;
        s = p >>> QUAT_BITS;
        return s[33:0];
    endfunction

endpackage

### rtl/core/adc_delay.sv
// fixed-length shift line that carries payload alongside the square root pipeline
// uses no package
module adc_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];
endmodule

### rtl/core/adc_isqrt.sv
// pipelined integer square root, one result bit per stage, saturated to 32 bits
// depends on adc_pkg
module adc_isqrt (
    input  logic          clk,
    input  logic [63:0]   radicand,
    output adc_pkg::fx_t  root
);
    import adc_pkg::*;

    logic [63:0] rem_reg  [SQRT_STEPS];
    logic [63:0] root_reg [SQRT_STEPS];
    logic [63:0] rem_in   [SQRT_STEPS];
    logic [63:0] root_in  [SQRT_STEPS];
    logic [63:0] rem_next [SQRT_STEPS];
    logic [63:0] root_next[SQRT_STEPS];
    logic [63:0] res;

    always_comb
    begin
        rem_in[0]  = radicand;
        root_in[0] = '0;
        for (int k = 1; k < SQRT_STEPS; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            // trial bit walks down two places per stage
            if (rem_in[k] >= root_in[k] + (64'd1 << (62 - 2 * k)))
            begin
                rem_next[k]  = rem_in[k] - (root_in[k] + (64'd1 << (62 - 2 * k)));
                root_next[k] = (root_in[k] >> 1) + (64'd1 << (62 - 2 * k));
            end
            else
            begin
                rem_next[k]  = rem_in[k];
                root_next[k] = root_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign res  = root_reg[SQRT_STEPS-1];
    assign root = (res > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : res[31:0];
endmodule

### rtl/core/adc_front.sv
// front stages: rotation matrix, velocity squares, body gravity and imbalance terms
// depends on adc_pkg
module adc_front #(
    parameter int FRAC_BITS = adc_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  adc_pkg::fx_t  quat_w,
    input  adc_pkg::fx_t  quat_x,
    input  adc_pkg::fx_t  quat_y,
    input  adc_pkg::fx_t  quat_z,
    input  adc_pkg::vec3_t lin_vel,
    input  adc_pkg::vec3_t rot_vel,
    input  adc_pkg::fx_t  drag_lin,
    input  adc_pkg::fx_t  drag_rot,
    input  adc_pkg::vec3_t grav,
    input  adc_pkg::vec3_t ecc,
    input  adc_pkg::fx_t  mass_delta,
    output adc_pkg::mat3_t m_q,
    output logic [63:0]   sum_lin_q,
    output logic [63:0]   sum_rot_q,
    output adc_pkg::vec3_t lv_q,
    output adc_pkg::vec3_t av_q,
    output adc_pkg::fx_t  dl_q,
    output adc_pkg::fx_t  dr_q,
    output adc_pkg::vec3_t fg_q,
    output adc_pkg::vec3_t tdm_q
);
    import adc_pkg::*;

    // stage 1
    qp_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic [62:0] sql_reg [3];
    logic [62:0] sqr_reg [3];
    vec3_t lv1_reg, av1_reg;
    fx_t   dl1_reg, dr1_reg;
    // stage 2
    mat3_t m2_reg, m2_next;
    logic [63:0] sl2_reg, sr2_reg;
    vec3_t lv2_reg, av2_reg;
    fx_t   dl2_reg, dr2_reg;
    // stages 3 to 7, gravity branch
    qp_t   mg3_reg [3][3];
    vec3_t gl4_reg;
    fx_t   pyz_reg, pzy_reg, pzx_reg, pxz_reg, pxy_reg, pyx_reg;
    vec3_t fg5_reg, fg6_reg, fg7_reg, cr6_reg, tdm7_reg;

    function automatic logic [62:0] square(input fx_t a);
        logic signed [63:0] p;
        p = a * a;
        return p[62:0];
    endfunction

    function automatic fx_t diag(input qp_t a, input qp_t b);
        logic signed [35:0] t;
        t = (36'sd1 <<< QUAT_BITS) - ((36'(a) + 36'(b)) <<< 1);
        return sat32(64'(t));
    endfunction

    function automatic fx_t offd(input qp_t a, input qp_t b, input logic sub);
        logic signed [35:0] t;
        t = sub ? (36'(a) - 36'(b)) : (36'(a) + 36'(b));
        return sat32(64'(t <<< 1));
    endfunction

    always_ff @(posedge clk)
    begin
        xx_reg <= qmul(quat_x, quat_x);
        yy_reg <= qmul(quat_y, quat_y);
        zz_reg <= qmul(quat_z, quat_z);
        xy_reg <= qmul(quat_x, quat_y);
        xz_reg <= qmul(quat_x, quat_z);
        yz_reg <= qmul(quat_y, quat_z);
        wx_reg <= qmul(quat_w, quat_x);
        wy_reg <= qmul(quat_w, quat_y);
        wz_reg <= qmul(quat_w, quat_z);
        for (int i = 0; i < 3; i++)
        begin
            sql_reg[i] <= square($signed(lin_vel[i]));
            sqr_reg[i] <= square($signed(rot_vel[i]));
        end
        lv1_reg <= lin_vel;
        av1_reg <= rot_vel;
        dl1_reg <= drag_lin;
        dr1_reg <= drag_rot;
    end

    // transpose of the attitude matrix
    always_comb
    begin
        m2_next[0][0] = diag(yy_reg, zz_reg);
        m2_next[0][1] = offd(xy_reg, wz_reg, 1'b0);
        m2_next[0][2] = offd(xz_reg, wy_reg, 1'b1);
        m2_next[1][0] = offd(xy_reg, wz_reg, 1'b1);
        m2_next[1][1] = diag(xx_reg, zz_reg);
        m2_next[1][2] = offd(yz_reg, wx_reg, 1'b0);
        m2_next[2][0] = offd(xz_reg, wy_reg, 1'b0);
        m2_next[2][1] = offd(yz_reg, wx_reg, 1'b1);
        m2_next[2][2] = diag(xx_reg, yy_reg);
    end

    always_ff @(posedge clk)
    begin
        m2_reg  <= m2_next;
        sl2_reg <= 64'(sql_reg[0]) + 64'(sql_reg[1]) + 64'(sql_reg[2]);
        sr2_reg <= 64'(sqr_reg[0]) + 64'(sqr_reg[1]) + 64'(sqr_reg[2]);
        lv2_reg <= lv1_reg;
        av2_reg <= av1_reg;
        dl2_reg <= dl1_reg;
        dr2_reg <= dr1_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mg3_reg[i][j] <= qmul($signed(m2_reg[i][j]), $signed(grav[j]));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            gl4_reg[i] <= sat32(64'(mg3_reg[i][0]) + 64'(mg3_reg[i][1])
                                + 64'(mg3_reg[i][2]));
        end
        // eccentricity cross local gravity, one product per term
        pyz_reg <= fmul($signed(ecc[1]), $signed(gl4_reg[2]), FRAC_BITS);
        pzy_reg <= fmul($signed(ecc[2]), $signed(gl4_reg[1]), FRAC_BITS);
        pzx_reg <= fmul($signed(ecc[2]), $signed(gl4_reg[0]), FRAC_BITS);
        pxz_reg <= fmul($signed(ecc[0]), $signed(gl4_reg[2]), FRAC_BITS);
        pxy_reg <= fmul($signed(ecc[0]), $signed(gl4_reg[1]), FRAC_BITS);
        pyx_reg <= fmul($signed(ecc[1]), $signed(gl4_reg[0]), FRAC_BITS);
        for (int i = 0; i < 3; i++)
        begin
            fg5_reg[i] <= fmul(mass_delta, $signed(gl4_reg[i]), FRAC_BITS);
        end
        cr6_reg[0] <= sat32(64'(pyz_reg) - 64'(pzy_reg));
        cr6_reg[1] <= sat32(64'(pzx_reg) - 64'(pxz_reg));
        cr6_reg[2] <= sat32(64'(pxy_reg) - 64'(pyx_reg));
        fg6_reg    <= fg5_reg;
        for (int i = 0; i < 3; i++)
        begin
            tdm7_reg[i] <= fmul(mass_delta, $signed(cr6_reg[i]), FRAC_BITS);
        end
        fg7_reg <= fg6_reg;
    end

    assign m_q       = m2_reg;
    assign sum_lin_q = sl2_reg;
    assign sum_rot_q = sr2_reg;
    assign lv_q      = lv2_reg;
    assign av_q      = av2_reg;
    assign dl_q      = dl2_reg;
    assign dr_q      = dr2_reg;
    assign fg_q      = fg7_reg;
    assign tdm_q     = tdm7_reg;
endmodule

### rtl/core/adc_back.sv
// back stages: drag scale, drag vectors, drag rotation, final sums and negation
// depends on adc_pkg
module adc_back #(
    parameter int FRAC_BITS = adc_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  adc_pkg::fx_t   norm_lin,
    input  adc_pkg::fx_t   norm_rot,
    input  adc_pkg::mat3_t m_in,
    input  adc_pkg::vec3_t lv_in,
    input  adc_pkg::vec3_t av_in,
    input  adc_pkg::fx_t   dl_in,
    input  adc_pkg::fx_t   dr_in,
    input  adc_pkg::vec3_t fg_in,
    input  adc_pkg::vec3_t tdm_in,
    output adc_pkg::vec3_t force_vec,
    output adc_pkg::vec3_t torque
);
    import adc_pkg::*;

    fx_t   kl_reg, kr_reg;
    mat3_t m1_reg, m2_reg;
    vec3_t lv1_reg, av1_reg;
    vec3_t fg1_reg, fg2_reg, fg3_reg, fg4_reg;
    vec3_t tdm1_reg, tdm2_reg, tdm3_reg;
    vec3_t d2_reg, td2_reg, td3_reg;
    qp_t   dp3_reg [3][3];
    vec3_t dr4_reg, tq4_reg;
    vec3_t force_reg, torque_reg;

    always_ff @(posedge clk)
    begin
        // drag scale k = -(coef * |v|)
        kl_reg   <= sat32(-64'(fmul(dl_in, norm_lin, FRAC_BITS)));
        kr_reg   <= sat32(-64'(fmul(dr_in, norm_rot, FRAC_BITS)));
        m1_reg   <= m_in;
        lv1_reg  <= lv_in;
        av1_reg  <= av_in;
        fg1_reg  <= fg_in;
        tdm1_reg <= tdm_in;

        for (int i = 0; i < 3; i++)
        begin
            d2_reg[i]  <= fmul(kl_reg, $signed(lv1_reg[i]), FRAC_BITS);
            td2_reg[i] <= fmul(kr_reg, $signed(av1_reg[i]), FRAC_BITS);
        end
        m2_reg   <= m1_reg;
        fg2_reg  <= fg1_reg;
        tdm2_reg <= tdm1_reg;

        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dp3_reg[i][j] <= qmul($signed(m2_reg[i][j]), $signed(d2_reg[j]));
            end
        end
        td3_reg  <= td2_reg;
        fg3_reg  <= fg2_reg;
        tdm3_reg <= tdm2_reg;

        for (int i = 0; i < 3; i++)
        begin
            dr4_reg[i] <= sat32(64'(dp3_reg[i][0]) + 64'(dp3_reg[i][1])
                                + 64'(dp3_reg[i][2]));
            tq4_reg[i] <= sat32(64'($signed(tdm3_reg[i])) + 64'($signed(td3_reg[i])));
        end
        fg4_reg <= fg3_reg;

        for (int i = 0; i < 3; i++)
        begin
            force_reg[i]  <= sat32(-64'(sat32(64'($signed(fg4_reg[i]))
                                              + 64'($signed(dr4_reg[i])))));
            torque_reg[i] <= sat32(-64'($signed(tq4_reg[i])));
        end
    end

    assign force_vec = force_reg;
    assign torque    = torque_reg;
endmodule

### rtl/core/airship_dynamic_compensation.sv
// top level of the airship dynamic compensation pipeline
// depends on adc_pkg, adc_front, adc_isqrt, adc_delay, adc_back
//
// usage
//  - one estimate set (attitude quaternion, velocities, drag coefficients) is
//    taken at every rising edge where start is high and busy is low
//  - busy never rises: the pipeline takes a new estimate set every cycle
//  - the result (negated force and torque, body frame, Q16.16 by default)
//    shows on the result ports for one cycle with done high, once its
//    estimate set has passed the front, square root and back stages
//  - results leave in the order their estimate sets came in
//  - latency is set by the velocity-norm square root, 32 stages of one
//    result bit each; rotation and gravity terms run alongside it
//  - throughput: one estimate set per clock, sustained
//  - the receiver cannot stall; done is a plain strobe, no back-pressure
//  - configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is
//    always high; index 0..6 selects gravity x/y/z, mass delta, ecc x/y/z,
//    other indexes are dropped; write only while no item is in flight
//  - reset (rst_n low, async) clears the in-flight valid bits and loads the
//    register defaults: gravity (0, 0, -9.81), everything else zero
module airship_dynamic_compensation #(
    parameter int FRAC_BITS = adc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  adc_pkg::fx_t                       quat_w,
    input  adc_pkg::fx_t                       quat_x,
    input  adc_pkg::fx_t                       quat_y,
    input  adc_pkg::fx_t                       quat_z,
    input  adc_pkg::fx_t                       lin_vel_x,
    input  adc_pkg::fx_t                       lin_vel_y,
    input  adc_pkg::fx_t                       lin_vel_z,
    input  adc_pkg::fx_t                       rot_vel_x,
    input  adc_pkg::fx_t                       rot_vel_y,
    input  adc_pkg::fx_t                       rot_vel_z,
    input  adc_pkg::fx_t                       drag_lin,
    input  adc_pkg::fx_t                       drag_rot,
    // result strobe
    output logic                               done,
    output adc_pkg::fx_t                       force_x,
    output adc_pkg::fx_t                       force_y,
    output adc_pkg::fx_t                       force_z,
    output adc_pkg::fx_t                       torque_x,
    output adc_pkg::fx_t                       torque_y,
    output adc_pkg::fx_t                       torque_z,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [adc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  adc_pkg::fx_t                       cfg_data
);
    import adc_pkg::*;

    // -9.81 in the chosen fraction width
    localparam fx_t GRAV_Z_RST = 32'(-((64'sd981 <<< FRAC_BITS) / 100));
    localparam int  CARRY_W    = 9 * 32 + 6 * 32 + 2 * 32;
    localparam int  GRAV_W     = 6 * 32;

    fx_t grav_x_reg, grav_y_reg, grav_z_reg, mass_d_reg;
    fx_t ecc_x_reg, ecc_y_reg, ecc_z_reg;
    logic [PIPE_LAT-1:0] vld_reg;

    mat3_t m_s2;
    logic [63:0] sum_lin_s2, sum_rot_s2;
    vec3_t lv_s2, av_s2, fg_s7, tdm_s7;
    fx_t   dl_s2, dr_s2;

    fx_t   norm_lin, norm_rot;
    mat3_t m_sn;
    vec3_t lv_sn, av_sn, fg_sn, tdm_sn;
    fx_t   dl_sn, dr_sn;
    vec3_t force_v, torque_v;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_x_reg <= '0;
            grav_y_reg <= '0;
            grav_z_reg <= GRAV_Z_RST;
            mass_d_reg <= '0;
            ecc_x_reg  <= '0;
            ecc_y_reg  <= '0;
            ecc_z_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRAV_X: grav_x_reg <= cfg_data;
                REG_GRAV_Y: grav_y_reg <= cfg_data;
                REG_GRAV_Z: grav_z_reg <= cfg_data;
                REG_MASS_D: mass_d_reg <= cfg_data;
                REG_ECC_X:  ecc_x_reg  <= cfg_data;
                REG_ECC_Y:  ecc_y_reg  <= cfg_data;
                REG_ECC_Z:  ecc_z_reg  <= cfg_data;
                default:    ; // unmapped index, write dropped
            endcase
        end
    end

    // valid bits travel with the data, one per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], start && !busy};
        end
    end

    assign done = vld_reg[PIPE_LAT-1];

    adc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .quat_w     (quat_w),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .lin_vel    ({lin_vel_z, lin_vel_y, lin_vel_x}),
        .rot_vel    ({rot_vel_z, rot_vel_y, rot_vel_x}),
        .drag_lin   (drag_lin),
        .drag_rot   (drag_rot),
        .grav       ({grav_z_reg, grav_y_reg, grav_x_reg}),
        .ecc        ({ecc_z_reg, ecc_y_reg, ecc_x_reg}),
        .mass_delta (mass_d_reg),
        .m_q        (m_s2),
        .sum_lin_q  (sum_lin_s2),
        .sum_rot_q  (sum_rot_s2),
        .lv_q       (lv_s2),
        .av_q       (av_s2),
        .dl_q       (dl_s2),
        .dr_q       (dr_s2),
        .fg_q       (fg_s7),
        .tdm_q      (tdm_s7)
    );

    // |v| and |w|
    adc_isqrt u_sqrt_lin (
        .clk      (clk),
        .radicand (sum_lin_s2),
        .root     (norm_lin)
    );

    adc_isqrt u_sqrt_rot (
        .clk      (clk),
        .radicand (sum_rot_s2),
        .root     (norm_rot)
    );

    // matrix, velocities and coefficients wait for the norms
    adc_delay #(
        .WIDTH (CARRY_W),
        .DEPTH (SQRT_STEPS)
    ) u_carry (
        .clk  (clk),
        .din  ({m_s2, lv_s2, av_s2, dl_s2, dr_s2}),
        .dout ({m_sn, lv_sn, av_sn, dl_sn, dr_sn})
    );

    // gravity terms finish early and wait too
    adc_delay #(
        .WIDTH (GRAV_W),
        .DEPTH (NORM_STAGE - GRAV_STAGE)
    ) u_grav (
        .clk  (clk),
        .din  ({fg_s7, tdm_s7}),
        .dout ({fg_sn, tdm_sn})
    );

    adc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .norm_lin  (norm_lin),
        .norm_rot  (norm_rot),
        .m_in      (m_sn),
        .lv_in     (lv_sn),
        .av_in     (av_sn),
        .dl_in     (dl_sn),
        .dr_in     (dr_sn),
        .fg_in     (fg_sn),
        .tdm_in    (tdm_sn),
        .force_vec (force_v),
        .torque    (torque_v)
    );

    assign force_x  = force_v[0];
    assign force_y  = force_v[1];
    assign force_z  = force_v[2];
    assign torque_x = torque_v[0];
    assign torque_y = torque_v[1];
    assign torque_z = torque_v[2];
endmodule

### rtl/core/adc_checker.sv
// port-level checks for the airship compensation block, bound to the top level
// depends on adc_pkg and airship_dynamic_compensation
module adc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);
    import adc_pkg::*;

    // every transfer yields its result after the fixed latency
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("result missing after accepted command");

    // no result without a transfer that latency ago
    a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without matching command");

    // fully pipelined: never refuses a command
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // configuration always taken
    a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");
endmodule

bind airship_dynamic_compensation adc_checker u_adc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

### tb/airship_dynamic_compensation_tb.sv
`timescale 1ns / 100ps
// self-checking bench for airship_dynamic_compensation: directed rows, then random estimate sets
// depends on adc_pkg and the rtl under rtl/core; the expected force/torque come from a local model
module airship_dynamic_compensation_tb;
    import adc_pkg::*;

    localparam int  FRAC      = 16;
    localparam int  QB        = 30;
    localparam int  NUM_REGS  = 7;
    localparam int  QUIET_MAX = 600;
    localparam int  PHASES    = 7;
    localparam int  PER_PHASE = 100;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;   // not decoded, write is dropped
    localparam longint ONE_Q  = 64'sd1 << QB;

    typedef struct {
        fx_t qw, qx, qy, qz;
        fx_t lv[3];
        fx_t av[3];
        fx_t dl, dr;
    } estimate_t;

    typedef struct {
        fx_t f[3];
        fx_t t[3];
    } wrench_t;

    typedef struct {
        estimate_t est;
        bit        typed;
        wrench_t   res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    fx_t  qw = '0, qx = '0, qy = '0, qz = '0;
    fx_t  lvx = '0, lvy = '0, lvz = '0, avx = '0, avy = '0, avz = '0;
    fx_t  dl = '0, dr = '0;
    logic done;
    fx_t  fx, fy, fz, tx, ty, tz;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    fx_t  cfg_data = '0;

    // shadow copy of the register file, updated on each write transfer to a decoded index
    longint reg_shadow[NUM_REGS];
    wrench_t wrench_q[$];
    int errors = 0;
    int quiet = 0;
    row_t rows[$];

    always #6 clk = ~clk;

    airship_dynamic_compensation u_top (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .quat_w(qw), .quat_x(qx), .quat_y(qy), .quat_z(qz),
        .lin_vel_x(lvx), .lin_vel_y(lvy), .lin_vel_z(lvz),
        .rot_vel_x(avx), .rot_vel_y(avy), .rot_vel_z(avz),
        .drag_lin(dl), .drag_rot(dr),
        .done(done),
        .force_x(fx), .force_y(fy), .force_z(fz),
        .torque_x(tx), .torque_y(ty), .torque_z(tz),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ---------------- fixed-point model of the compensation math ----------------

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, floored then clamped
    function automatic longint qmul_fx(longint a, longint b);
        return clamp32((a * b) >>> FRAC);
    endfunction

    // quaternion-scale product, floored by 30 bits, not clamped
    function automatic longint qmul_q(longint a, longint b);
        return (a * b) >>> QB;
    endfunction

    function automatic longint vec_norm(longint a, longint b, longint c);
        longint unsigned n;
        longint unsigned r;
        longint unsigned bt;
        n = longint'(a * a) + longint'(b * b) + longint'(c * c);
        r = 0;
        bt = 64'd1 << 62;
        while (bt > n)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (n >= r + bt)
            begin
                n = n - (r + bt);
                r = (r >> 1) + bt;
            end
            else
                r = r >> 1;
            bt = bt >> 2;
        end
        return clamp32(longint'(r));
    endfunction

    function automatic void rotate_body(input longint m[3][3], input longint v[3],
                                        output longint o[3]);
        for (int i = 0; i < 3; i++)
            o[i] = clamp32(qmul_q(m[i][0], v[0]) + qmul_q(m[i][1], v[1])
                           + qmul_q(m[i][2], v[2]));
    endfunction

    // quadratic drag -coef*|v|*v
    function automatic void quad_drag(input longint coef, input longint v[3],
                                      output longint o[3]);
        longint k;
        k = clamp32(-qmul_fx(coef, vec_norm(v[0], v[1], v[2])));
        for (int i = 0; i < 3; i++)
            o[i] = qmul_fx(k, v[i]);
    endfunction

    function automatic wrench_t compensation_of(estimate_t e);
        longint w, x, y, z;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint m[3][3];
        longint lv[3], av[3], g[3], ecc[3], gl[3], d[3], drr[3], cr[3], td[3];
        longint dm;
        wrench_t r;
        w = e.qw; x = e.qx; y = e.qy; z = e.qz;
        xx = qmul_q(x, x); yy = qmul_q(y, y); zz = qmul_q(z, z);
        xy = qmul_q(x, y); xz = qmul_q(x, z); yz = qmul_q(y, z);
        wx = qmul_q(w, x); wy = qmul_q(w, y); wz = qmul_q(w, z);
        // transpose of the body-to-world matrix
        m[0][0] = clamp32(ONE_Q - 2 * (yy + zz));
        m[0][1] = clamp32(2 * (xy + wz));
        m[0][2] = clamp32(2 * (xz - wy));
        m[1][0] = clamp32(2 * (xy - wz));
        m[1][1] = clamp32(ONE_Q - 2 * (xx + zz));
        m[1][2] = clamp32(2 * (yz + wx));
        m[2][0] = clamp32(2 * (xz + wy));
        m[2][1] = clamp32(2 * (yz - wx));
        m[2][2] = clamp32(ONE_Q - 2 * (xx + yy));
        for (int i = 0; i < 3; i++)
        begin
            lv[i]  = e.lv[i];
            av[i]  = e.av[i];
            g[i]   = reg_shadow[i];
            ecc[i] = reg_shadow[4 + i];
        end
        dm = reg_shadow[3];
        rotate_body(m, g, gl);
        quad_drag(e.dl, lv, d);
        rotate_body(m, d, drr);
        quad_drag(e.dr, av, td);
        cr[0] = clamp32(qmul_fx(ecc[1], gl[2]) - qmul_fx(ecc[2], gl[1]));
        cr[1] = clamp32(qmul_fx(ecc[2], gl[0]) - qmul_fx(ecc[0], gl[2]));
        cr[2] = clamp32(qmul_fx(ecc[0], gl[1]) - qmul_fx(ecc[1], gl[0]));
        for (int i = 0; i < 3; i++)
        begin
            r.f[i] = fx_t'(clamp32(-clamp32(qmul_fx(dm, gl[i]) + drr[i])));
            r.t[i] = fx_t'(clamp32(-clamp32(qmul_fx(dm, cr[i]) + td[i])));
        end
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, fx_t got, fx_t want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // results are sampled at the edge that ends their strobe cycle
    always @(posedge clk)
    begin
        wrench_t want;
        fx_t got_f[3];
        fx_t got_t[3];
        if (rst_n && done)
        begin
            got_f = '{fx, fy, fz};
            got_t = '{tx, ty, tz};
            if (wrench_q.size() == 0)
            begin
                errors++;
                $display("unexpected result transfer at %0t", $time);
            end
            else
            begin
                want = wrench_q.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (got_f[i] !== want.f[i])
                        report_mismatch($sformatf("force[%0d]", i), got_f[i], want.f[i]);
                    if (got_t[i] !== want.t[i])
                        report_mismatch($sformatf("torque[%0d]", i), got_t[i], want.t[i]);
                end
            end
        end
        // watchdog: any transfer counts as progress
        if (!rst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    // one register transfer; valid stays up when another write follows
    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, longint val, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= fx_t'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NUM_REGS)
            reg_shadow[idx] = clamp32(longint'(fx_t'(val)));
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // start is only lowered when a gap follows, so it never drops and rises in one step
    task automatic send_estimate(estimate_t e, bit typed, wrench_t want, int gap);
        start <= 1'b1;
        qw <= e.qw; qx <= e.qx; qy <= e.qy; qz <= e.qz;
        lvx <= e.lv[0]; lvy <= e.lv[1]; lvz <= e.lv[2];
        avx <= e.av[0]; avy <= e.av[1]; avz <= e.av[2];
        dl <= e.dl; dr <= e.dr;
        do
            @(posedge clk);
        while (busy);
        wrench_q.push_back(typed ? want : compensation_of(e));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let the pipeline empty before touching the registers
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (wrench_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic estimate_t make_est(fx_t a, fx_t b, fx_t c, fx_t d,
                                           fx_t l0, fx_t l1, fx_t l2,
                                           fx_t a0, fx_t a1, fx_t a2, fx_t cl, fx_t cr);
        estimate_t e;
        e.qw = a; e.qx = b; e.qy = c; e.qz = d;
        e.lv = '{l0, l1, l2};
        e.av = '{a0, a1, a2};
        e.dl = cl; e.dr = cr;
        return e;
    endfunction

    function automatic fx_t rand_quat_part();
        return fx_t'($signed({1'b0, $urandom_range(32'h8000_0000, 0)}) - 33'sd1073741824);
    endfunction

    // mostly moderate magnitudes, sometimes the full 32-bit range
    function automatic fx_t rand_val();
        if ($urandom_range(9, 0) < 3)
            return fx_t'($urandom);
        return fx_t'($signed({1'b0, $urandom_range(32'h0080_0000, 0)}) - 33'sd4194304);
    endfunction

    function automatic estimate_t rand_estimate();
        return make_est(rand_quat_part(), rand_quat_part(), rand_quat_part(),
                        rand_quat_part(), rand_val(), rand_val(), rand_val(),
                        rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
    endfunction

    // one register setting per phase, including the all-max and all-min extremes
    task automatic program_setting(int kind);
        longint v;
        for (int i = 0; i <= NUM_REGS; i++)
        begin
            case (kind)
                0: v = 64'sd2147483647;
                1: v = -64'sd2147483648;
                2: v = 0;
                3: v = longint'($signed($urandom));
                default: v = longint'($signed({1'b0, $urandom_range(32'h0040_0000, 0)}))
                             - 64'sd2097152;
            endcase
            if (i == NUM_REGS)
                reg_write(REG_NONE, longint'($signed($urandom)), 1'b1);
            else
                reg_write(i[CFG_IDX_W-1:0], v, 1'b0);
        end
    endtask

    initial
    begin
        wrench_t zero_w;
        wrench_t none;
        int gap;
        bit idle_on;
        fx_t mx;
        fx_t mn;
        fx_t q1;
        mx = 32'sh7FFFFFFF;
        mn = 32'sh80000000;
        q1 = 32'sh40000000;
        zero_w.f = '{default: '0};
        zero_w.t = '{default: '0};
        none = zero_w;
        // register defaults after reset: gravity (0, 0, -9.81), rest zero
        for (int i = 0; i < NUM_REGS; i++)
            reg_shadow[i] = 0;
        reg_shadow[REG_GRAV_Z] = -(64'sd981 << FRAC) / 100;

        // directed rows: identity and zero attitudes with zero drag give zero output
        rows.push_back('{make_est(q1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_w});
        rows.push_back('{make_est(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_w});
        rows.push_back('{make_est(q1, 0, 0, 0, mx, mn, mx, mn, mx, mn, 0, 0), 1'b1, zero_w});
        // half turns about each axis
        rows.push_back('{make_est(0, q1, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0,
                                  32'sh8000, 32'sh8000), 1'b0, none});
        rows.push_back('{make_est(0, 0, q1, 0, 0, 32'sh20000, 0, 0, 0, 32'sh20000,
                                  32'sh10000, 32'sh10000), 1'b0, none});
        rows.push_back('{make_est(0, 0, 0, q1, 0, 0, 32'sh30000, 32'sh30000, 0, 0,
                                  32'sh18000, 32'sh4000), 1'b0, none});
        // non-unit quaternions: the rotation scales, entries saturate
        rows.push_back('{make_est(q1, q1, q1, q1, 32'sh10000, 32'sh10000, 32'sh10000,
                                  32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
                                  32'sh10000), 1'b0, none});
        rows.push_back('{make_est(-q1, -q1, -q1, -q1, -32'sh10000, 32'sh20000, -32'sh30000,
                                  32'sh40000, -32'sh50000, 32'sh60000, -32'sh10000,
                                  -32'sh10000), 1'b0, none});
        rows.push_back('{make_est(-q1, q1, -q1, q1, 0, 0, 0, 0, 0, 0, mx, mn), 1'b0, none});
        // saturation everywhere: extreme speeds and drag coefficients
        rows.push_back('{make_est(q1, 0, 0, 0, mx, mx, mx, mx, mx, mx, mx, mx), 1'b0, none});
        rows.push_back('{make_est(q1, 0, 0, 0, mn, mn, mn, mn, mn, mn, mn, mn), 1'b0, none});
        rows.push_back('{make_est(q1, 0, 0, 0, mn, mn, mn, mn, mn, mn, mx, mx), 1'b0, none});
        rows.push_back('{make_est(0, q1, 0, 0, mx, mn, mx, mn, mx, mn, mn, mx), 1'b0, none});
        rows.push_back('{make_est(32'sh2D413CCD, 32'sh2D413CCD, 0, 0, 32'sh0000FFFF,
                                  -32'sh1, 32'sh1, -32'sh1, 32'sh1, 32'sh0000FFFF,
                                  32'sh1, -32'sh1), 1'b0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, first with reset defaults
        foreach (rows[i])
            send_estimate(rows[i].est, rows[i].typed, rows[i].res, $urandom_range(3, 0));
        drain();
        // same rows against an extreme register setting
        program_setting(0);
        foreach (rows[i])
            send_estimate(rows[i].est, 1'b0, none, 0);
        drain();

        // random phases, each with its own register setting; drain before each write
        for (int p = 0; p < PHASES; p++)
        begin
            program_setting((p + 1) % 5);
            idle_on = (p % 3) != 0;
            for (int n = 0; n < PER_PHASE; n++)
            begin
                gap = idle_on ? $urandom_range(13, 0) : 0;
                send_estimate(rand_estimate(), 1'b0, none, gap);
            end
            drain();
        end

        // tail: wait out the pipeline latency once nothing is expected
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (errors == 0 && wrench_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/core/adc_pkg.sv
rtl/core/adc_delay.sv
rtl/core/adc_isqrt.sv
rtl/core/adc_front.sv
rtl/core/adc_back.sv
rtl/core/airship_dynamic_compensation.sv
rtl/core/adc_checker.sv
tb/airship_dynamic_compensation_tb.sv
